// ===== src/pfa_pkg.sv =====
package pfa_pkg;

  localparam int FRAMES    = 64;
  localparam int FRAME_W   = 6;
  localparam int CNT_W     = 7;
  localparam int PROCESSES = 16;
  localparam int PROC_W    = 4;
  localparam int MAX_PAGES = 16;
  localparam int PAGE_W    = 4;
  localparam int NEED_W    = 5;
  localparam int TOT_W     = 32;
  localparam int ST_W      = 3;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 80;

  localparam logic [ST_W-1:0] ST_GRANT    = 3'd0;
  localparam logic [ST_W-1:0] ST_RESIDENT = 3'd1;
  localparam logic [ST_W-1:0] ST_REFUSED  = 3'd2;
  localparam logic [ST_W-1:0] ST_FREED    = 3'd3;
  localparam logic [ST_W-1:0] ST_NOT_RES  = 3'd4;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

endpackage

// ===== src/paged_frame_allocator_core.sv =====
// Frame allocator: a FIFO of free frame numbers plus a per-process frame list. A request
// beat is taken only while the sequencer is idle. A decision state follows the accept; an
// allocate of n pages then moves one frame per cycle through the free-list memory port
// (n result beats) while the result side is not stalled; a free of a slot owning n frames
// returns one frame per cycle to the list, then sends the freed beat; the other outcomes
// are single beats. A stall on the result side holds any state that is sending a beat.
// Writing cfg_wr_data sets the pool size (values above 64 act as 64), refills the free
// list in ascending order and drops all residency in the same cycle; totals are kept.
module paged_frame_allocator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [pfa_pkg::CNT_W-1:0]         cfg_wr_data,   // frame_count
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pfa_pkg::IN_DATA_W-1:0]     in_tdata,      // process_id, required_pages
  input  logic [0:0]                        in_tuser,      // func
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pfa_pkg::OUT_DATA_W-1:0]    out_tdata,     // frame, free_frames, paged_in, paged_out
  output logic [pfa_pkg::ST_W-1:0]          out_tuser,     // status
  output logic                              out_tlast
);
  import pfa_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_ALLOC  = 2'd2;
  localparam logic [1:0] S_FREE   = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic                 func_r, func_nxt;
  logic [PROC_W-1:0]    slot_r, slot_nxt;
  logic [NEED_W-1:0]    need_r, need_nxt;
  logic [NEED_W-1:0]    idx_r, idx_nxt;
  logic [FRAME_W-1:0]   head_r, head_nxt;
  logic [FRAME_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]     free_r, free_nxt;
  logic [TOT_W-1:0]     in_tot_r, in_tot_nxt;
  logic [TOT_W-1:0]     out_tot_r, out_tot_nxt;
  logic [PROCESSES-1:0] res_r, res_nxt;
  logic [FRAMES-1:0]    fvld_r, fvld_nxt;

  logic [FRAME_W-1:0]   fifo_mem [FRAMES];
  logic [FRAME_W-1:0]   fifo_rd_q;
  logic [FRAME_W-1:0]   ft_mem [PROCESSES*MAX_PAGES];
  logic [FRAME_W-1:0]   ft_rd_q;
  logic [NEED_W-1:0]    owned_r [PROCESSES];

  logic                 out_valid_r;
  logic [ST_W-1:0]      out_status_r;
  logic [FRAME_W-1:0]   out_frame_r;
  logic                 out_last_r;
  logic [CNT_W-1:0]     out_free_r;
  logic [TOT_W-1:0]     out_in_r;
  logic [TOT_W-1:0]     out_out_r;

  logic                 emit_ok;
  logic                 emit;
  logic [ST_W-1:0]      e_status;
  logic [FRAME_W-1:0]   e_frame;
  logic                 e_last;
  logic                 fifo_we;
  logic                 ft_we;
  logic                 own_we;
  logic [FRAME_W-1:0]   fifo_q;
  logic                 alloc_last;
  logic [CNT_W-1:0]     cfg_n;

  // entries never written since the last refill read as their own index
  assign fifo_q     = fvld_r[head_r] ? fifo_rd_q : head_r;
  assign emit_ok    = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign alloc_last = (idx_r == need_r - NEED_W'(1));
  assign cfg_n      = (cfg_wr_data > CNT_W'(FRAMES)) ? CNT_W'(FRAMES) : cfg_wr_data;

  always_comb begin
    state_nxt   = state_r;
    func_nxt    = func_r;
    slot_nxt    = slot_r;
    need_nxt    = need_r;
    idx_nxt     = idx_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    free_nxt    = free_r;
    in_tot_nxt  = in_tot_r;
    out_tot_nxt = out_tot_r;
    res_nxt     = res_r;
    fvld_nxt    = fvld_r;
    emit        = 1'b0;
    e_status    = ST_GRANT;
    e_frame     = '0;
    e_last      = 1'b1;
    fifo_we     = 1'b0;
    ft_we       = 1'b0;
    own_we      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          func_nxt  = in_tuser[0];
          slot_nxt  = in_tdata[PROC_W-1:0];
          need_nxt  = in_tdata[PROC_W +: NEED_W];
          idx_nxt   = '0;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (emit_ok) begin
          if (func_r == FUNC_ALLOC) begin
            if (res_r[slot_r]) begin
              emit      = 1'b1;
              e_status  = ST_RESIDENT;
              state_nxt = S_IDLE;
            end else if (need_r == '0 || need_r > NEED_W'(MAX_PAGES) ||
                         CNT_W'(need_r) > free_r) begin
              emit      = 1'b1;
              e_status  = ST_REFUSED;
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_ALLOC;
            end
          end else begin
            if (!res_r[slot_r]) begin
              emit      = 1'b1;
              e_status  = ST_NOT_RES;
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_FREE;
            end
          end
        end
      end
      S_ALLOC: begin
        if (emit_ok) begin
          emit     = 1'b1;
          e_status = ST_GRANT;
          e_frame  = fifo_q;
          e_last   = alloc_last;
          ft_we    = 1'b1;
          head_nxt = head_r + FRAME_W'(1);
          free_nxt = free_r - CNT_W'(1);
          if (in_tot_r != '1) in_tot_nxt = in_tot_r + TOT_W'(1);
          if (alloc_last) begin
            own_we         = 1'b1;
            res_nxt[slot_r] = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            idx_nxt = idx_r + NEED_W'(1);
          end
        end
      end
      S_FREE: begin
        if (idx_r == owned_r[slot_r] || free_r == CNT_W'(FRAMES)) begin
          if (emit_ok) begin
            emit            = 1'b1;
            e_status        = ST_FREED;
            res_nxt[slot_r] = 1'b0;
            state_nxt       = S_IDLE;
          end
        end else begin
          fifo_we          = 1'b1;
          fvld_nxt[tail_r] = 1'b1;
          tail_nxt         = tail_r + FRAME_W'(1);
          free_nxt         = free_r + CNT_W'(1);
          if (out_tot_r != '1) out_tot_nxt = out_tot_r + TOT_W'(1);
          idx_nxt          = idx_r + NEED_W'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_wr_en) begin
      head_nxt = '0;
      tail_nxt = cfg_n[FRAME_W-1:0];
      free_nxt = cfg_n;
      res_nxt  = '0;
      fvld_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      free_r      <= CNT_W'(FRAMES);
      in_tot_r    <= '0;
      out_tot_r   <= '0;
      res_r       <= '0;
      fvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      free_r    <= free_nxt;
      in_tot_r  <= in_tot_nxt;
      out_tot_r <= out_tot_nxt;
      res_r     <= res_nxt;
      fvld_r    <= fvld_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    slot_r <= slot_nxt;
    need_r <= need_nxt;
    idx_r  <= idx_nxt;
    if (own_we) owned_r[slot_r] <= need_r;
    if (emit) begin
      out_status_r <= e_status;
      out_frame_r  <= e_frame;
      out_last_r   <= e_last;
      out_free_r   <= free_nxt;
      out_in_r     <= in_tot_nxt;
      out_out_r    <= out_tot_nxt;
    end
  end

  // free list: written at the tail on release, read at the next head address so the head entry is registered
  always_ff @(posedge clk) begin
    if (fifo_we) fifo_mem[tail_r] <= ft_rd_q;
    fifo_rd_q <= fifo_mem[head_nxt];
  end

  // per-slot frame lists, row = slot, column = page
  always_ff @(posedge clk) begin
    if (ft_we) ft_mem[{slot_r, idx_r[PAGE_W-1:0]}] <= fifo_q;
    ft_rd_q <= ft_mem[{slot_nxt, idx_nxt[PAGE_W-1:0]}];
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_out_r, out_in_r, out_free_r, out_frame_r};

endmodule

// ===== src/pfa_chk.sv =====
module pfa_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [pfa_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [pfa_pkg::ST_W-1:0]       out_tuser,
  input logic                           out_tlast
);
  import pfa_pkg::*;

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // every non-grant outcome is a single beat
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_GRANT |-> out_tlast)
    else $error("single-beat outcome without last");

  a_zero_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_GRANT |-> out_tdata[FRAME_W-1:0] == '0)
    else $error("frame field nonzero on non-grant outcome");

  // request port closes right after a request beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == ST_GRANT || out_tuser == ST_RESIDENT ||
                   out_tuser == ST_REFUSED || out_tuser == ST_FREED ||
                   out_tuser == ST_NOT_RES)
    else $error("unknown status code");

endmodule

bind paged_frame_allocator_core pfa_chk u_pfa_chk (.*);
